@@ rtl/framed_packet_decoder_top_macros.svh @@
// assertion macros for the framed packet decoder
`ifndef FRAMED_PACKET_DECODER_TOP_MACROS_SVH
`define FRAMED_PACKET_DECODER_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define FPD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define FPD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/fpd_pkg.sv @@
// shared constants, types and crc function for the framed packet decoder
`default_nettype none
package fpd_pkg;

	// frame limits
	localparam int WIRE_MAX    = 514;
	localparam int LOGICAL_MAX = 256;
	localparam int WIRE_MIN    = 9;
	localparam int LOGICAL_MIN = 7;
	localparam int HEADER_LEN  = 5;

	localparam int WIRE_CNT_W = $clog2(WIRE_MAX + 2);
	localparam int LOG_CNT_W  = $clog2(LOGICAL_MAX + 2);
	localparam int HDR_IDX_W  = $clog2(HEADER_LEN);

	// byte codes
	localparam logic [7:0] FLAG_BYTE = 8'h7E;
	localparam logic [7:0] ESC_BYTE  = 8'h7D;
	localparam logic [7:0] ESC_XOR   = 8'h20;

	localparam logic [7:0] PAYLOAD_LIMIT_RST = 8'd249;

	// crc-16/modbus, reflected
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_WIRE_LEN = 3'd1,
		ST_FLAG     = 3'd2,
		ST_ESCAPE   = 3'd3,
		ST_LENGTH   = 3'd4,
		ST_CRC      = 3'd5,
		ST_LIMIT    = 3'd6
	} fpd_status_t;

	typedef enum logic {
		KIND_PAYLOAD = 1'b0,
		KIND_SUMMARY = 1'b1
	} fpd_kind_t;

	typedef struct packed {
		logic [7:0] wire_byte;
		logic       end_of_frame;
	} fpd_item_t;

	typedef struct packed {
		fpd_kind_t   kind;
		logic [7:0]  data_byte;
		fpd_status_t status;
		logic [7:0]  device_id;
		logic [7:0]  function_code;
		logic [15:0] sequence_res;
		logic [7:0]  payload_count;
	} fpd_result_t;

	// one byte of crc update, eight shift steps
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage
`default_nettype wire

@@ rtl/fpd_ifs.sv @@
// valid/ready channel interfaces for wire bytes, results and configuration
`default_nettype none

interface fpd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] wire_byte;
	logic       end_of_frame;
	modport source(output valid, output wire_byte, output end_of_frame, input ready);
	modport sink(input valid, input wire_byte, input end_of_frame, output ready);
endinterface

interface fpd_out_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [7:0]  data_byte;
	logic [2:0]  status;
	logic [7:0]  device_id;
	logic [7:0]  function_code;
	logic [15:0] sequence_res;
	logic [7:0]  payload_count;
	modport source(output valid, output kind, output data_byte, output status,
		output device_id, output function_code, output sequence_res,
		output payload_count, input ready);
	modport sink(input valid, input kind, input data_byte, input status,
		input device_id, input function_code, input sequence_res,
		input payload_count, output ready);
endinterface

interface fpd_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] payload_limit;
	modport source(output valid, output payload_limit, input ready);
	modport sink(input valid, input payload_limit, output ready);
endinterface

`default_nettype wire

@@ rtl/fpd_decode_core.sv @@
// per-frame state and combinational unstuffing, crc and frame checks
`default_nettype none
module fpd_decode_core import fpd_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        step,
	input  wire fpd_item_t   item,
	input  wire logic [7:0]  payload_limit,
	output logic             res_valid,
	output fpd_result_t      res
);

	logic [WIRE_CNT_W-1:0] wire_cnt_q, wire_cnt_inc;
	logic [LOG_CNT_W-1:0]  log_cnt_q, log_cnt_d;
	logic                  esc_q, esc_d;
	logic [15:0]           crc_q, crc_d;
	fpd_status_t           err_q, err_d;
	logic [7:0]            delay_q [2];
	logic [7:0]            header_q [HEADER_LEN];

	logic                  first, lc_full, push, shift, crc_en, emit, hdr_wr;
	logic [7:0]            unesc, push_val;
	logic [LOG_CNT_W-1:0]  lc_minus_one, lc_minus_min;
	fpd_status_t           sum_status;

	// unstuffing, counters and crc next state
	always_comb begin
		first        = (wire_cnt_q == '0);
		wire_cnt_inc = (wire_cnt_q <= WIRE_CNT_W'(WIRE_MAX)) ? wire_cnt_q + 1'b1 : wire_cnt_q;
		unesc        = item.wire_byte ^ ESC_XOR;
		lc_full      = (log_cnt_q >= LOG_CNT_W'(LOGICAL_MAX));
		push         = 1'b0;
		push_val     = item.wire_byte;
		esc_d        = esc_q;
		err_d        = err_q;
		if (first && item.wire_byte != FLAG_BYTE && !item.end_of_frame) begin
			err_d = ST_FLAG;
		end
		if (!item.end_of_frame && !first) begin
			if (esc_q) begin
				esc_d = 1'b0;
				if (unesc == FLAG_BYTE || unesc == ESC_BYTE) begin
					push     = 1'b1;
					push_val = unesc;
				end else if (err_q == ST_OK) begin
					err_d = ST_ESCAPE;
				end
			end else if (item.wire_byte == ESC_BYTE) begin
				esc_d = 1'b1;
			end else begin
				push = 1'b1;
			end
		end
		shift  = push && !lc_full;
		crc_en = shift && (log_cnt_q >= LOG_CNT_W'(2));
		emit   = crc_en && (log_cnt_q >= LOG_CNT_W'(HEADER_LEN + 2)) && (err_q == ST_OK);
		hdr_wr = shift && (log_cnt_q < LOG_CNT_W'(HEADER_LEN));
		if (push) begin
			log_cnt_d = lc_full ? LOG_CNT_W'(LOGICAL_MAX + 1) : log_cnt_q + 1'b1;
		end else begin
			log_cnt_d = log_cnt_q;
		end
		crc_d = crc_en ? crc16_byte(crc_q, delay_q[0]) : crc_q;
	end

	// end-of-frame checks in priority order
	always_comb begin
		lc_minus_one = log_cnt_q - 1'b1;
		lc_minus_min = log_cnt_q - LOG_CNT_W'(LOGICAL_MIN);
		if (wire_cnt_inc < WIRE_CNT_W'(WIRE_MIN) || wire_cnt_inc > WIRE_CNT_W'(WIRE_MAX)) begin
			sum_status = ST_WIRE_LEN;
		end else if (err_q == ST_FLAG || item.wire_byte != FLAG_BYTE) begin
			sum_status = ST_FLAG;
		end else if (err_q == ST_ESCAPE || esc_q) begin
			sum_status = ST_ESCAPE;
		end else if (log_cnt_q < LOG_CNT_W'(LOGICAL_MIN) ||
				log_cnt_q > LOG_CNT_W'(LOGICAL_MAX) ||
				LOG_CNT_W'(header_q[0]) != lc_minus_one) begin
			sum_status = ST_LENGTH;
		end else if (crc_q != {delay_q[0], delay_q[1]}) begin
			sum_status = ST_CRC;
		end else if (lc_minus_min > LOG_CNT_W'(payload_limit)) begin
			sum_status = ST_LIMIT;
		end else begin
			sum_status = ST_OK;
		end
	end

	// result selection
	always_comb begin
		res       = '0;
		res_valid = 1'b0;
		if (item.end_of_frame) begin
			res_valid  = step;
			res.kind   = KIND_SUMMARY;
			res.status = sum_status;
			if (sum_status == ST_OK) begin
				res.device_id     = header_q[1];
				res.function_code = header_q[2];
				res.sequence_res  = {header_q[3], header_q[4]};
				res.payload_count = lc_minus_min[7:0];
			end
		end else if (emit) begin
			res_valid     = step;
			res.kind      = KIND_PAYLOAD;
			res.data_byte = delay_q[0];
		end
	end

	// frame control state, cleared after each summary
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wire_cnt_q <= '0;
			log_cnt_q  <= '0;
			esc_q      <= 1'b0;
			crc_q      <= CRC_INIT;
			err_q      <= ST_OK;
		end else if (step) begin
			if (item.end_of_frame) begin
				wire_cnt_q <= '0;
				log_cnt_q  <= '0;
				esc_q      <= 1'b0;
				crc_q      <= CRC_INIT;
				err_q      <= ST_OK;
			end else begin
				wire_cnt_q <= wire_cnt_inc;
				log_cnt_q  <= log_cnt_d;
				esc_q      <= esc_d;
				crc_q      <= crc_d;
				err_q      <= err_d;
			end
		end
	end

	// two-byte delay line and header capture
	always_ff @(posedge clk) begin
		if (step && shift) begin
			delay_q[0] <= delay_q[1];
			delay_q[1] <= push_val;
			if (hdr_wr) begin
				header_q[log_cnt_q[HDR_IDX_W-1:0]] <= push_val;
			end
		end
	end

endmodule
`default_nettype wire

@@ rtl/framed_packet_decoder_top.sv @@
// Framed packet decoder: takes one stuffed wire byte per transaction and returns
// provisional payload bytes and one summary per frame. A new byte is accepted
// every clock cycle while results are taken; a byte's result passes through the input
// register and then the result register. The rate is set by the byte-wide crc-16
// update and frame checks, done combinationally between the two registers. Payload
// bytes trail the logical byte stream by two bytes, so the crc bytes are never
// emitted. The user must write payload_limit only while the block is idle; the block
// itself does not enforce this.
`default_nettype none
`include "framed_packet_decoder_top_macros.svh"
module framed_packet_decoder_top import fpd_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	fpd_in_if.sink     wire_ch,
	fpd_out_if.source  result_ch,
	fpd_cfg_if.sink    cfg
);

	logic        valid_s1;
	fpd_item_t   item_s1;
	logic        res_valid_s2;
	fpd_result_t res_s2;
	logic [7:0]  payload_limit_q;

	logic        out_free, advance, core_valid;
	fpd_result_t core_res;

	// handshake control
	assign out_free      = !res_valid_s2 || result_ch.ready;
	assign advance       = valid_s1 && out_free;
	assign wire_ch.ready = !valid_s1 || out_free;
	assign cfg.ready     = 1'b1;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			payload_limit_q <= PAYLOAD_LIMIT_RST;
		end else if (cfg.valid) begin
			payload_limit_q <= cfg.payload_limit;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (wire_ch.valid && wire_ch.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wire_ch.valid && wire_ch.ready) begin
			item_s1.wire_byte    <= wire_ch.wire_byte;
			item_s1.end_of_frame <= wire_ch.end_of_frame;
		end
	end

	fpd_decode_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (advance),
		.item          (item_s1),
		.payload_limit (payload_limit_q),
		.res_valid     (core_valid),
		.res           (core_res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (out_free) begin
			res_valid_s2 <= core_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && core_valid) begin
			res_s2 <= core_res;
		end
	end

	assign result_ch.valid         = res_valid_s2;
	assign result_ch.kind          = res_s2.kind;
	assign result_ch.data_byte     = res_s2.data_byte;
	assign result_ch.status        = res_s2.status;
	assign result_ch.device_id     = res_s2.device_id;
	assign result_ch.function_code = res_s2.function_code;
	assign result_ch.sequence_res  = res_s2.sequence_res;
	assign result_ch.payload_count = res_s2.payload_count;

	// checks
	`FPD_ASSERT_NEXT(a_eof_gives_summary, advance && item_s1.end_of_frame, res_valid_s2 && res_s2.kind == KIND_SUMMARY, "end of frame produced no summary")
	`FPD_ASSERT_NEXT(a_stalled_input_held, valid_s1 && !out_free, valid_s1 && $stable(item_s1), "input register lost a stalled transaction")
	`FPD_ASSERT_NOW(a_payload_clean, res_valid_s2 && res_s2.kind == KIND_PAYLOAD, res_s2.status == ST_OK && res_s2.payload_count == 8'd0, "payload result carries summary fields")
	`FPD_ASSERT_NOW(a_reject_zeroed, res_valid_s2 && res_s2.kind == KIND_SUMMARY && res_s2.status != ST_OK, res_s2.device_id == 8'd0 && res_s2.sequence_res == 16'd0 && res_s2.payload_count == 8'd0, "rejected frame reports header fields")

endmodule
`default_nettype wire

@@ test/tb.sv @@
// testbench for the framed packet decoder: directed and random framed traffic checked against a predictor
module tb;
	import fpd_pkg::*;

	typedef bit [7:0] octet_t;

	typedef enum {
		FK_GOOD, FK_BAD_CRC, FK_BAD_LEN, FK_BAD_START, FK_BAD_END, FK_BAD_ESC,
		FK_DANGLING, FK_RAW_FLAG, FK_NOISE, FK_SINGLE, FK_SHORT, FK_LONG_LOGICAL,
		FK_LONG_WIRE
	} frame_kind_t;

	localparam int HOLD_CYCLES   = 300;
	localparam int QUIET_LIMIT   = 4000;
	localparam int SETTLE_CYCLES = 6;
	localparam int PHASE_ITEMS   = 205;
	localparam int IDLE_PERCENT  = 16;

	// decoder predictor and store of awaited results
	class frame_checker;
		octet_t      limit;
		int unsigned wire_cnt;
		bit          esc_open;
		int unsigned log_cnt;
		bit [15:0]   crc;
		octet_t      lag[2];
		octet_t      hdr[HEADER_LEN];
		fpd_status_t first_err;
		fpd_result_t awaited[$];
		int          errors;
		int          status_seen[8];
		int          payload_seen;

		function new();
			limit = PAYLOAD_LIMIT_RST;
			errors = 0;
			payload_seen = 0;
			foreach (status_seen[i]) status_seen[i] = 0;
			restart();
		endfunction

		// per-frame state back to its idle value
		function void restart();
			wire_cnt = 0;
			esc_open = 0;
			log_cnt = 0;
			crc = CRC_INIT;
			lag[0] = 0;
			lag[1] = 0;
			foreach (hdr[i]) hdr[i] = 0;
			first_err = ST_OK;
		endfunction

		static function bit [15:0] crc_update(bit [15:0] c, octet_t b);
			bit [15:0] r;
			r = c ^ {8'h00, b};
			repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
			return r;
		endfunction

		function void push_expected(fpd_kind_t k, octet_t d, fpd_status_t s, octet_t dev,
			octet_t func, bit [15:0] seq, octet_t cnt);
			fpd_result_t r;
			r.kind = k;
			r.data_byte = d;
			r.status = s;
			r.device_id = dev;
			r.function_code = func;
			r.sequence_res = seq;
			r.payload_count = cnt;
			awaited.push_back(r);
		endfunction

		// one unstuffed byte; payload leaves the two-byte delay line
		function void add_logical(octet_t v);
			if (log_cnt >= LOGICAL_MAX) begin
				log_cnt = LOGICAL_MAX + 1;
				return;
			end
			if (log_cnt < HEADER_LEN) hdr[log_cnt] = v;
			if (log_cnt >= 2) begin
				crc = crc_update(crc, lag[0]);
				if (log_cnt - 2 >= HEADER_LEN && first_err == ST_OK)
					push_expected(KIND_PAYLOAD, lag[0], ST_OK, 0, 0, 0, 0);
			end
			lag[0] = lag[1];
			lag[1] = v;
			log_cnt++;
		endfunction

		function void take_wire_byte(octet_t b, bit eof);
			bit          first;
			octet_t      v;
			fpd_status_t st;
			int unsigned lc;
			first = (wire_cnt == 0);
			if (first) begin
				crc = CRC_INIT;
				if (b != FLAG_BYTE && !eof) first_err = ST_FLAG;
			end
			if (wire_cnt <= WIRE_MAX) wire_cnt++;

			// inner bytes: unstuff
			if (!eof) begin
				if (!first) begin
					if (esc_open) begin
						v = b ^ ESC_XOR;
						esc_open = 0;
						if (v != FLAG_BYTE && v != ESC_BYTE) begin
							if (first_err == ST_OK) first_err = ST_ESCAPE;
						end else begin
							add_logical(v);
						end
					end else if (b == ESC_BYTE) begin
						esc_open = 1;
					end else begin
						add_logical(b);
					end
				end
				return;
			end

			// closing byte: checks in priority order
			lc = log_cnt;
			st = ST_OK;
			if (wire_cnt < WIRE_MIN || wire_cnt > WIRE_MAX)
				st = ST_WIRE_LEN;
			else if (first_err == ST_FLAG || b != FLAG_BYTE)
				st = ST_FLAG;
			else if (first_err == ST_ESCAPE || esc_open)
				st = ST_ESCAPE;
			else if (lc < LOGICAL_MIN || lc > LOGICAL_MAX || hdr[0] != lc - 1)
				st = ST_LENGTH;
			else if (crc != {lag[0], lag[1]})
				st = ST_CRC;
			else if (lc - LOGICAL_MIN > limit)
				st = ST_LIMIT;
			if (st == ST_OK)
				push_expected(KIND_SUMMARY, 0, ST_OK, hdr[1], hdr[2], {hdr[3], hdr[4]},
					octet_t'(lc - LOGICAL_MIN));
			else
				push_expected(KIND_SUMMARY, 0, st, 0, 0, 0, 0);
			restart();
		endfunction

		function void match_field(string field, bit [15:0] want, logic [15:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: %s expected %h actual %h", $time, field, want, got);
			end
		endfunction

		function void check_result(fpd_result_t got);
			fpd_result_t want;
			if (awaited.size() == 0) begin
				errors++;
				$display("%0t: result with nothing awaited, expected none actual kind %0d status %0d",
					$time, got.kind, got.status);
				return;
			end
			want = awaited.pop_front();
			match_field("kind", want.kind, got.kind);
			match_field("data_byte", want.data_byte, got.data_byte);
			match_field("status", want.status, got.status);
			match_field("device_id", want.device_id, got.device_id);
			match_field("function_code", want.function_code, got.function_code);
			match_field("sequence_res", want.sequence_res, got.sequence_res);
			match_field("payload_count", want.payload_count, got.payload_count);
			if (want.kind == KIND_SUMMARY) status_seen[want.status]++;
			else payload_seen++;
		endfunction

		function int pending();
			return awaited.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	fpd_in_if  wire_if();
	fpd_out_if res_if();
	fpd_cfg_if cfg_if();

	framed_packet_decoder_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.wire_ch   (wire_if),
		.result_ch (res_if),
		.cfg       (cfg_if)
	);

	frame_checker frame_chk = new();
	bit [8:0]     frame_bytes[$];
	int           items_sent;
	int           frames_sent;
	int           limits_used;
	bit           calm;
	bit           hold_req;
	int           hold_left;
	fpd_result_t  seen;

	// clock
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic bit take_break();
		return !calm && $urandom_range(99) < IDLE_PERCENT;
	endfunction

	// bytes biased towards flag and escape codes
	function automatic octet_t pick_byte();
		int r;
		r = $urandom_range(7);
		if (r == 0) return FLAG_BYTE;
		if (r == 1) return ESC_BYTE;
		return octet_t'($urandom);
	endfunction

	function automatic octet_t not_flag();
		octet_t x;
		x = octet_t'($urandom);
		if (x == FLAG_BYTE) x ^= 8'h01;
		return x;
	endfunction

	// logical frame with crc, optional damage, then stuffing onto the wire
	function automatic void wrap_frame(frame_kind_t kind, octet_t dev, octet_t func,
		bit [15:0] seq, octet_t payload[$]);
		octet_t    lg[$];
		bit [15:0] c;
		int        bad_at;
		octet_t    x;
		lg.push_back(octet_t'(payload.size() + 6));
		if (kind == FK_BAD_LEN) lg[0] += octet_t'($urandom_range(1, 255));
		lg.push_back(dev);
		lg.push_back(func);
		lg.push_back(seq[15:8]);
		lg.push_back(seq[7:0]);
		foreach (payload[i]) lg.push_back(payload[i]);
		c = CRC_INIT;
		foreach (lg[i]) c = frame_checker::crc_update(c, lg[i]);
		lg.push_back(c[15:8]);
		lg.push_back(c[7:0]);
		if (kind == FK_BAD_CRC)
			lg[lg.size() - 1 - $urandom_range(0, 1)] ^= 8'h01 << $urandom_range(0, 7);
		if (kind == FK_SHORT) lg.delete(2);

		frame_bytes.delete();
		frame_bytes.push_back({1'b0, (kind == FK_BAD_START) ? not_flag() : FLAG_BYTE});
		bad_at = $urandom_range(0, lg.size() - 1);
		foreach (lg[k]) begin
			if (k == bad_at && kind == FK_BAD_ESC) begin
				x = octet_t'($urandom);
				if ((x ^ ESC_XOR) == FLAG_BYTE || (x ^ ESC_XOR) == ESC_BYTE) x ^= 8'h01;
				frame_bytes.push_back({1'b0, ESC_BYTE});
				frame_bytes.push_back({1'b0, x});
			end
			if (k == bad_at && kind == FK_RAW_FLAG) frame_bytes.push_back({1'b0, FLAG_BYTE});
			if (lg[k] == FLAG_BYTE || lg[k] == ESC_BYTE) begin
				frame_bytes.push_back({1'b0, ESC_BYTE});
				frame_bytes.push_back({1'b0, lg[k] ^ ESC_XOR});
			end else begin
				frame_bytes.push_back({1'b0, lg[k]});
			end
		end
		if (kind == FK_DANGLING) frame_bytes.push_back({1'b0, ESC_BYTE});
		frame_bytes.push_back({1'b1, (kind == FK_BAD_END) ? not_flag() : FLAG_BYTE});
	endfunction

	function automatic frame_kind_t pick_kind();
		int r;
		r = $urandom_range(999);
		if (r < 580) return FK_GOOD;
		if (r < 640) return FK_BAD_CRC;
		if (r < 690) return FK_BAD_LEN;
		if (r < 730) return FK_BAD_START;
		if (r < 770) return FK_BAD_END;
		if (r < 820) return FK_BAD_ESC;
		if (r < 860) return FK_DANGLING;
		if (r < 900) return FK_RAW_FLAG;
		if (r < 950) return FK_NOISE;
		if (r < 970) return FK_SINGLE;
		if (r < 990) return FK_SHORT;
		if (r < 995) return FK_LONG_LOGICAL;
		return FK_LONG_WIRE;
	endfunction

	// mostly short payloads, now and then one near the largest
	function automatic void build_random_frame();
		frame_kind_t kind;
		octet_t      payload[$];
		int          n;
		int          r;
		kind = pick_kind();
		frame_bytes.delete();
		if (kind == FK_SINGLE) begin
			frame_bytes.push_back({1'b1, pick_byte()});
			return;
		end
		if (kind == FK_NOISE) begin
			n = $urandom_range(1, 24);
			for (int i = 0; i < n; i++) frame_bytes.push_back({i == n - 1, pick_byte()});
			return;
		end
		r = $urandom_range(99);
		if (kind == FK_LONG_LOGICAL) n = $urandom_range(250, 262);
		else if (kind == FK_LONG_WIRE) n = 255;
		else if (r < 90) n = $urandom_range(0, 12);
		else if (r < 98) n = $urandom_range(13, 48);
		else n = $urandom_range(200, 249);
		for (int i = 0; i < n; i++)
			payload.push_back((kind == FK_LONG_WIRE) ? FLAG_BYTE : pick_byte());
		wrap_frame(kind, pick_byte(), pick_byte(), {pick_byte(), pick_byte()}, payload);
	endfunction

	// one wire byte, held until the transaction completes
	task automatic drive_byte(octet_t b, bit eof);
		@(negedge clk);
		while (take_break()) begin
			wire_if.valid <= 1'b0;
			@(negedge clk);
		end
		wire_if.valid <= 1'b1;
		wire_if.wire_byte <= b;
		wire_if.end_of_frame <= eof;
		do @(posedge clk); while (wire_if.ready !== 1'b1);
		items_sent++;
		frame_chk.take_wire_byte(b, eof);
	endtask

	task automatic send_frame();
		foreach (frame_bytes[i]) drive_byte(frame_bytes[i][7:0], frame_bytes[i][8]);
		frames_sent++;
	endtask

	// stop sending and let every awaited result come out
	task automatic settle();
		@(negedge clk);
		wire_if.valid <= 1'b0;
		while (frame_chk.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(octet_t v);
		@(negedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.payload_limit <= v;
		do @(posedge clk); while (cfg_if.ready !== 1'b1);
		frame_chk.limit = v;
		limits_used++;
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	// result side: random stalls plus one long hold-off on request
	initial begin
		res_if.ready = 1'b0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_if.ready <= 1'b0;
			end else begin
				res_if.ready <= arst_n && !take_break();
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
			seen.kind = fpd_kind_t'(res_if.kind);
			seen.data_byte = res_if.data_byte;
			seen.status = fpd_status_t'(res_if.status);
			seen.device_id = res_if.device_id;
			seen.function_code = res_if.function_code;
			seen.sequence_res = res_if.sequence_res;
			seen.payload_count = res_if.payload_count;
			frame_chk.check_result(seen);
		end
	end

	// watchdog on cycles without any transaction
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((wire_if.valid === 1'b1 && wire_if.ready === 1'b1) ||
				(res_if.valid === 1'b1 && res_if.ready === 1'b1) ||
				(cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
		$display("Mismatches found");
		$finish;
	end

	// stimulus
	initial begin
		octet_t limit_plan[6];
		octet_t one_byte[$];
		bit     paused;
		int     target;
		arst_n = 1'b0;
		wire_if.valid = 1'b0;
		wire_if.wire_byte = 8'h00;
		wire_if.end_of_frame = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.payload_limit = 8'h00;
		calm = 0;
		hold_req = 0;
		paused = 0;
		items_sent = 0;
		frames_sent = 0;
		limits_used = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: single-byte frame, smallest good frame, escaped header and payload
		frame_bytes.delete();
		frame_bytes.push_back({1'b1, FLAG_BYTE});
		send_frame();
		wrap_frame(FK_GOOD, 8'hFF, 8'h00, 16'hFFFF, one_byte);
		send_frame();
		one_byte.push_back(ESC_BYTE);
		wrap_frame(FK_GOOD, FLAG_BYTE, ESC_BYTE, {8'h00, FLAG_BYTE}, one_byte);
		send_frame();

		// random phases, each under its own payload limit
		limit_plan = '{8'd0, 8'd255, PAYLOAD_LIMIT_RST, 8'd0, 8'd3, 8'd0};
		limit_plan[3] = octet_t'($urandom_range(1, 248));
		limit_plan[5] = octet_t'($urandom_range(0, 249));
		for (int p = 0; p < 6; p++) begin
			settle();
			write_limit(limit_plan[p]);
			calm = (p == 2);
			if (p == 1) hold_req = 1;
			target = items_sent + PHASE_ITEMS;
			while (items_sent < target) begin
				build_random_frame();
				send_frame();
				if (p == 3 && !paused && items_sent > target - PHASE_ITEMS / 2) begin
					paused = 1;
					settle();
				end
			end
			calm = 0;
		end

		settle();
		$display("covered %0d frames, %0d wire bytes and %0d payload bytes under %0d limit settings",
			frames_sent, items_sent, frame_chk.payload_seen, limits_used);
		$display("summaries: ok %0d, wire length %0d, flag %0d, escape %0d, length %0d, crc %0d, limit %0d",
			frame_chk.status_seen[ST_OK], frame_chk.status_seen[ST_WIRE_LEN],
			frame_chk.status_seen[ST_FLAG], frame_chk.status_seen[ST_ESCAPE],
			frame_chk.status_seen[ST_LENGTH], frame_chk.status_seen[ST_CRC],
			frame_chk.status_seen[ST_LIMIT]);
		if (frame_chk.errors == 0 && frame_chk.pending() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("%0t: %0d errors, %0d results still awaited", $time, frame_chk.errors,
				frame_chk.pending());
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/fpd_pkg.sv
rtl/fpd_ifs.sv
rtl/fpd_decode_core.sv
rtl/framed_packet_decoder_top.sv
test/tb.sv
